[rtl/core/clr_pkg.sv]
// shared constants and types of the clipped line rasteriser
package clr_pkg;

    // fixed field widths
    localparam int unsigned CLIP_BITS   = 15;
    localparam int unsigned ORIGIN_BITS = 16;
    localparam int unsigned COLOR_BITS  = 32;
    localparam int unsigned OUT_BITS    = 17;

    // configuration port
    localparam int unsigned DATA_BITS = 32;
    localparam int unsigned ADDR_BITS = 5;
    localparam int unsigned IDX_BITS  = 3;

    // register indexes, byte address is four times the index
    typedef enum logic [IDX_BITS-1:0] {
        REG_CLIP_WIDTH      = 3'd0,
        REG_CLIP_HEIGHT     = 3'd1,
        REG_ORIGIN_X        = 3'd2,
        REG_ORIGIN_Y        = 3'd3,
        REG_OFFSET_ENABLE   = 3'd4,
        REG_TRANSPARENT_KEY = 3'd5
    } reg_index_t;

    // command kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

endpackage

[rtl/core/clr_cmd_if.sv]
// command channel: line start or single step beats
interface clr_cmd_if #(
    parameter int unsigned COORD_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic                          kind;
    logic signed [COORD_BITS-1:0]  x_start;
    logic signed [COORD_BITS-1:0]  y_start;
    logic signed [COORD_BITS-1:0]  x_end;
    logic signed [COORD_BITS-1:0]  y_end;
    logic [clr_pkg::COLOR_BITS-1:0] line_color;

    modport source (
        output valid, kind, x_start, y_start, x_end, y_end, line_color,
        input  ready
    );
    modport sink (
        input  valid, kind, x_start, y_start, x_end, y_end, line_color,
        output ready
    );
endinterface

[rtl/core/clr_pix_if.sv]
// pixel channel: one result beat per command beat
interface clr_pix_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 pixel_valid;
    logic                                 visible;
    logic signed [clr_pkg::OUT_BITS-1:0]  pixel_x;
    logic signed [clr_pkg::OUT_BITS-1:0]  pixel_y;
    logic [clr_pkg::COLOR_BITS-1:0]       pixel_color;
    logic                                 last;

    modport source (
        output valid, pixel_valid, visible, pixel_x, pixel_y, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_valid, visible, pixel_x, pixel_y, pixel_color, last,
        output ready
    );
endinterface

[rtl/core/clipped_line_rasterizer_core.sv]
// Bresenham line walker with clip test: a start beat loads the endpoints and
// colour and returns the first pixel unless its colour is the transparent key,
// every step of an active line the next pixel; one result beat per command
// beat. A command is accepted every clock while the result register is empty
// or being drained, so the walker sustains one pixel per cycle through the
// single result register after the step and clip logic. Unenforced: the user
// writes the APB-style configuration port only with no line work in flight.
module clipped_line_rasterizer_core #(
    parameter int unsigned COORD_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [clr_pkg::ADDR_BITS-1:0]       paddr,
    input  logic [clr_pkg::DATA_BITS-1:0]       pwdata,
    output logic [clr_pkg::DATA_BITS-1:0]       prdata,
    output logic                                pready,
    // channels
    clr_cmd_if.sink                             cmd,
    clr_pix_if.source                           pix
);

    localparam int unsigned C = COORD_BITS;
    localparam int unsigned D = COORD_BITS + 1;
    localparam int unsigned E = COORD_BITS + 3;
    localparam int unsigned S = ((COORD_BITS > clr_pkg::ORIGIN_BITS) ?
                                 COORD_BITS : clr_pkg::ORIGIN_BITS) + 1;
    localparam int unsigned OB = clr_pkg::OUT_BITS;
    localparam int unsigned CB = clr_pkg::CLIP_BITS;
    localparam int unsigned GB = clr_pkg::ORIGIN_BITS;

    // configuration registers
    logic [CB-1:0]                    clip_width_reg;
    logic [CB-1:0]                    clip_height_reg;
    logic [GB-1:0]                    origin_x_reg;
    logic [GB-1:0]                    origin_y_reg;
    logic                             offset_enable_reg;
    logic [clr_pkg::COLOR_BITS-1:0]   transparent_key_reg;

    // line state
    logic                             active_reg;
    logic [C-1:0]                     cur_x_reg;
    logic [C-1:0]                     cur_y_reg;
    logic [C-1:0]                     goal_x_reg;
    logic [C-1:0]                     goal_y_reg;
    logic [D-1:0]                     dx_reg;
    logic [D-1:0]                     dy_reg;
    logic                             step_left_reg;
    logic                             step_up_reg;
    logic [E-1:0]                     err_reg;
    logic [clr_pkg::COLOR_BITS-1:0]   color_reg;

    // result register
    logic                             res_valid_reg;
    logic                             res_pixel_valid_reg;
    logic                             res_visible_reg;
    logic [OB-1:0]                    res_x_reg;
    logic [OB-1:0]                    res_y_reg;
    logic [clr_pkg::COLOR_BITS-1:0]   res_color_reg;
    logic                             res_last_reg;

    // next values
    logic                             res_pixel_valid_next;
    logic                             res_visible_next;
    logic [OB-1:0]                    res_x_next;
    logic [OB-1:0]                    res_y_next;
    logic [clr_pkg::COLOR_BITS-1:0]   res_color_next;
    logic                             res_last_next;
    logic [C-1:0]                     cur_x_next;
    logic [C-1:0]                     cur_y_next;
    logic [E-1:0]                     err_next;

    logic                             cfg_write;
    logic [clr_pkg::IDX_BITS-1:0]     cfg_idx;
    logic                             accept;
    logic                             is_start;
    logic                             transparent;
    logic                             emit;
    logic                             at_goal;

    logic [D-1:0]                     diff_x;
    logic [D-1:0]                     diff_y;
    logic [D-1:0]                     abs_dx;
    logic [D-1:0]                     abs_dy;
    logic [E-1:0]                     err_start;
    logic [E-1:0]                     e2;
    logic [E-1:0]                     dx_e;
    logic [E-1:0]                     dy_e;
    logic                             move_x;
    logic                             move_y;
    logic [C-1:0]                     step_x;
    logic [C-1:0]                     step_y;
    logic [C-1:0]                     pix_x;
    logic [C-1:0]                     pix_y;
    logic [S-1:0]                     x_ext;
    logic [S-1:0]                     y_ext;
    logic [S-1:0]                     sum_x;
    logic [S-1:0]                     sum_y;
    logic                             add_origin;

    // configuration write and read
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[clr_pkg::ADDR_BITS-1:2];
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_width_reg      <= '0;
            clip_height_reg     <= '0;
            origin_x_reg        <= '0;
            origin_y_reg        <= '0;
            offset_enable_reg   <= 1'b0;
            transparent_key_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                clr_pkg::REG_CLIP_WIDTH:      clip_width_reg      <= pwdata[CB-1:0];
                clr_pkg::REG_CLIP_HEIGHT:     clip_height_reg     <= pwdata[CB-1:0];
                clr_pkg::REG_ORIGIN_X:        origin_x_reg        <= pwdata[GB-1:0];
                clr_pkg::REG_ORIGIN_Y:        origin_y_reg        <= pwdata[GB-1:0];
                clr_pkg::REG_OFFSET_ENABLE:   offset_enable_reg   <= pwdata[0];
                clr_pkg::REG_TRANSPARENT_KEY: transparent_key_reg <= pwdata;
                default:                      ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            clr_pkg::REG_CLIP_WIDTH:
                prdata = {{(clr_pkg::DATA_BITS-CB){1'b0}}, clip_width_reg};
            clr_pkg::REG_CLIP_HEIGHT:
                prdata = {{(clr_pkg::DATA_BITS-CB){1'b0}}, clip_height_reg};
            clr_pkg::REG_ORIGIN_X:
                prdata = {{(clr_pkg::DATA_BITS-GB){1'b0}}, origin_x_reg};
            clr_pkg::REG_ORIGIN_Y:
                prdata = {{(clr_pkg::DATA_BITS-GB){1'b0}}, origin_y_reg};
            clr_pkg::REG_OFFSET_ENABLE:
                prdata = {{(clr_pkg::DATA_BITS-1){1'b0}}, offset_enable_reg};
            clr_pkg::REG_TRANSPARENT_KEY:
                prdata = transparent_key_reg;
            default:
                prdata = '0;
        endcase
    end

    // handshake: the result register parts the two sides
    assign cmd.ready = !res_valid_reg || pix.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign is_start  = (cmd.kind == clr_pkg::KIND_START);
    assign transparent = (cmd.line_color == transparent_key_reg);

    // start set-up: absolute deltas and initial error
    assign diff_x = {cmd.x_end[C-1], cmd.x_end} - {cmd.x_start[C-1], cmd.x_start};
    assign diff_y = {cmd.y_end[C-1], cmd.y_end} - {cmd.y_start[C-1], cmd.y_start};
    assign abs_dx = diff_x[D-1] ? (~diff_x + D'(1)) : diff_x;
    assign abs_dy = diff_y[D-1] ? (~diff_y + D'(1)) : diff_y;
    assign err_start = {{(E-D){1'b0}}, abs_dx} - {{(E-D){1'b0}}, abs_dy};

    // one bresenham step from the held state
    assign dx_e   = {{(E-D){1'b0}}, dx_reg};
    assign dy_e   = {{(E-D){1'b0}}, dy_reg};
    assign e2     = {err_reg[E-2:0], 1'b0};
    assign move_x = $signed(e2) > $signed(~dy_e + E'(1));
    assign move_y = $signed(e2) < $signed(dx_e);
    assign step_x = cur_x_reg + (step_left_reg ? {C{1'b1}} : C'(1));
    assign step_y = cur_y_reg + (step_up_reg ? {C{1'b1}} : C'(1));
    assign err_next = err_reg - (move_x ? dy_e : '0) + (move_y ? dx_e : '0);
    assign cur_x_next = move_x ? step_x : cur_x_reg;
    assign cur_y_next = move_y ? step_y : cur_y_reg;

    // pixel of this beat and end-point test
    assign pix_x   = is_start ? cmd.x_start : cur_x_next;
    assign pix_y   = is_start ? cmd.y_start : cur_y_next;
    assign at_goal = is_start ? (cmd.x_start == cmd.x_end && cmd.y_start == cmd.y_end)
                              : (cur_x_next == goal_x_reg && cur_y_next == goal_y_reg);
    assign emit    = is_start ? !transparent : active_reg;

    // clip test and origin offset
    assign x_ext = {{(S-C){pix_x[C-1]}}, pix_x};
    assign y_ext = {{(S-C){pix_y[C-1]}}, pix_y};
    assign res_visible_next = !pix_x[C-1] && !pix_y[C-1]
        && (x_ext < {{(S-CB){1'b0}}, clip_width_reg})
        && (y_ext < {{(S-CB){1'b0}}, clip_height_reg});
    assign add_origin = res_visible_next && offset_enable_reg;
    assign sum_x = x_ext + (add_origin ? {{(S-GB){origin_x_reg[GB-1]}}, origin_x_reg} : '0);
    assign sum_y = y_ext + (add_origin ? {{(S-GB){origin_y_reg[GB-1]}}, origin_y_reg} : '0);

    // result fields, zero when no pixel is produced
    assign res_pixel_valid_next = emit;
    assign res_x_next     = emit ? sum_x[OB-1:0] : '0;
    assign res_y_next     = emit ? sum_y[OB-1:0] : '0;
    assign res_color_next = !emit ? '0 : (is_start ? cmd.line_color : color_reg);
    assign res_last_next  = emit && at_goal;

    // line state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else if (accept && emit)
        begin
            active_reg <= !at_goal;
        end
        else if (accept && is_start)
        begin
            active_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && is_start && !transparent)
        begin
            cur_x_reg     <= cmd.x_start;
            cur_y_reg     <= cmd.y_start;
            goal_x_reg    <= cmd.x_end;
            goal_y_reg    <= cmd.y_end;
            dx_reg        <= abs_dx;
            dy_reg        <= abs_dy;
            step_left_reg <= !($signed(cmd.x_start) < $signed(cmd.x_end));
            step_up_reg   <= !($signed(cmd.y_start) < $signed(cmd.y_end));
            err_reg       <= err_start;
            color_reg     <= cmd.line_color;
        end
        else if (accept && !is_start && active_reg)
        begin
            cur_x_reg <= cur_x_next;
            cur_y_reg <= cur_y_next;
            err_reg   <= err_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (pix.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_pixel_valid_reg <= res_pixel_valid_next;
            res_visible_reg     <= emit && res_visible_next;
            res_x_reg           <= res_x_next;
            res_y_reg           <= res_y_next;
            res_color_reg       <= res_color_next;
            res_last_reg        <= res_last_next;
        end
    end

    // result beat
    assign pix.valid       = res_valid_reg;
    assign pix.pixel_valid = res_pixel_valid_reg;
    assign pix.visible     = res_visible_reg;
    assign pix.pixel_x     = res_x_reg;
    assign pix.pixel_y     = res_y_reg;
    assign pix.pixel_color = res_color_reg;
    assign pix.last        = res_last_reg;

endmodule
